// ===== rtl/line_ray_distance_3d_unit_assert.svh =====
// assertion macros shared by the line/ray distance checker
`ifndef LINE_RAY_DISTANCE_3D_UNIT_ASSERT_SVH
`define LINE_RAY_DISTANCE_3D_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LRD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication after a fixed number of cycles, checked outside reset
`define LRD_ASSERT_LAT(lbl, ante, lat, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##lat (cons)) \
        else $error(msg);

`endif

// ===== rtl/lrd_pkg.sv =====
// types and constants for the line/ray distance unit
`timescale 1ns / 1ps

package lrd_pkg;

    typedef struct packed {
        logic signed [31:0] line_origin_x;
        logic signed [31:0] line_origin_y;
        logic signed [31:0] line_origin_z;
        logic signed [31:0] line_dir_x;
        logic signed [31:0] line_dir_y;
        logic signed [31:0] line_dir_z;
        logic signed [31:0] ray_origin_x;
        logic signed [31:0] ray_origin_y;
        logic signed [31:0] ray_origin_z;
        logic signed [31:0] ray_dir_x;
        logic signed [31:0] ray_dir_y;
        logic signed [31:0] ray_dir_z;
    } item_t;

    typedef struct packed {
        logic [63:0]        squared_distance;
        logic [31:0]        distance;
        logic signed [31:0] line_param;
        logic [30:0]        ray_param;
        logic signed [31:0] line_point_x;
        logic signed [31:0] line_point_y;
        logic signed [31:0] line_point_z;
        logic signed [31:0] ray_point_x;
        logic signed [31:0] ray_point_y;
        logic signed [31:0] ray_point_z;
        logic [1:0]         closest_case;
    } result_t;

    localparam logic [1:0] CASE_INTERIOR = 2'd0;
    localparam logic [1:0] CASE_CLAMPED  = 2'd1;
    localparam logic [1:0] CASE_PARALLEL = 2'd2;

    localparam logic [30:0] TOL_RESET = 31'd1074;

    // quotient bits and root bits, one per pipeline stage
    localparam int DIV_STAGES  = 31;
    localparam int SQRT_STAGES = 32;

    // stage numbers along the pipe, stage 0 is the input register
    localparam int ST_DIV_IN  = 6;
    localparam int ST_DIV_OUT = ST_DIV_IN + DIV_STAGES;
    localparam int ST_SEL     = ST_DIV_OUT + 1;
    localparam int ST_CLAMP   = ST_SEL + 3;
    localparam int ST_SQ      = ST_SEL + 5;
    localparam int ST_ROOT    = ST_SQ + SQRT_STAGES;
    localparam int ST_OUT     = ST_ROOT + 1;
    localparam int LATENCY    = ST_OUT + 1;

endpackage

// ===== rtl/lrd_delay.sv =====
// fixed-length shift line that keeps side data aligned with the pipe
`timescale 1ns / 1ps

module lrd_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        tap_reg[0] <= din;
        for (int i = 1; i < DEPTH; i++)
        begin
            tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// ===== rtl/lrd_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module lrd_div (
    input  logic                            clk,
    input  logic [lrd_pkg::DIV_STAGES-1:0]  dvs,
    input  logic [lrd_pkg::DIV_STAGES-1:0]  rem_in,
    input  logic [lrd_pkg::DIV_STAGES-1:0]  low_in,
    output logic [lrd_pkg::DIV_STAGES-1:0]  quo
);

    localparam int N = lrd_pkg::DIV_STAGES;

    logic [N-1:0] dvs_reg [1:N-1];
    logic [N-1:0] rem_reg [1:N-1];
    logic [N-1:0] low_reg [1:N-1];
    logic [N-1:0] quo_reg [1:N];

    genvar k;
    for (k = 1; k <= N; k++)
    begin : g_stage
        logic [N-1:0] dvs_prev;
        logic [N-1:0] rem_prev;
        logic [N-1:0] low_prev;
        logic [N-1:0] quo_prev;
        logic [N:0]   rem_sh;
        logic [N:0]   rem_sub;
        logic         ge;

        if (k == 1)
        begin : g_first
            assign dvs_prev = dvs;
            assign rem_prev = rem_in;
            assign low_prev = low_in;
            assign quo_prev = '0;
        end
        else
        begin : g_next
            assign dvs_prev = dvs_reg[k-1];
            assign rem_prev = rem_reg[k-1];
            assign low_prev = low_reg[k-1];
            assign quo_prev = quo_reg[k-1];
        end

        // bring down the next dividend bit and try the subtract
        assign rem_sh  = {rem_prev, low_prev[N-1]};
        assign rem_sub = rem_sh - {1'b0, dvs_prev};
        assign ge      = (rem_sh >= {1'b0, dvs_prev});

        always_ff @(posedge clk)
        begin
            quo_reg[k] <= {quo_prev[N-2:0], ge};
        end

        if (k < N)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                dvs_reg[k] <= dvs_prev;
                rem_reg[k] <= ge ? rem_sub[N-1:0] : rem_sh[N-1:0];
                low_reg[k] <= {low_prev[N-2:0], 1'b0};
            end
        end
    end

    assign quo = quo_reg[N];

endmodule

// ===== rtl/lrd_sqrt.sv =====
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps

module lrd_sqrt (
    input  logic                             clk,
    input  logic [2*lrd_pkg::SQRT_STAGES-1:0] x_in,
    output logic [lrd_pkg::SQRT_STAGES-1:0]  root
);

    localparam int N  = lrd_pkg::SQRT_STAGES;
    localparam int XW = 2 * N;
    localparam int RW = N + 2;

    logic [XW-1:0] x_reg    [1:N-1];
    logic [RW-1:0] rem_reg  [1:N-1];
    logic [N-1:0]  root_reg [1:N];

    genvar k;
    for (k = 1; k <= N; k++)
    begin : g_stage
        logic [XW-1:0] x_prev;
        logic [RW-1:0] rem_prev;
        logic [N-1:0]  root_prev;
        logic [RW+1:0] rem_sh;
        logic [RW+1:0] trial;
        logic [RW+1:0] rem_sub;
        logic          ge;

        if (k == 1)
        begin : g_first
            assign x_prev    = x_in;
            assign rem_prev  = '0;
            assign root_prev = '0;
        end
        else
        begin : g_next
            assign x_prev    = x_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
        end

        // trial value is 4*root + 1 against the remainder with two new bits
        assign rem_sh  = {rem_prev, x_prev[XW-1:XW-2]};
        assign trial   = {2'b00, root_prev, 2'b01};
        assign rem_sub = rem_sh - trial;
        assign ge      = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            root_reg[k] <= {root_prev[N-2:0], ge};
        end

        if (k < N)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                x_reg[k]   <= {x_prev[XW-3:0], 2'b00};
                rem_reg[k] <= ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
            end
        end
    end

    assign root = root_reg[N];

endmodule

// ===== rtl/line_ray_distance_3d_unit.sv =====
// top level of the line/ray closest-approach pipeline
`timescale 1ns / 1ps

// closest approach between a 3d line and a 3d ray, fixed point.
// input: one item per transfer, taken at a clock edge where start is high
// and busy is low. busy never rises, so a new item can enter every cycle.
// output: done is high for exactly one cycle with the result alongside;
// the receiver cannot hold results off and none is needed.
// pipe: it holds the 31-stage divider (one quotient bit per stage) and the
// 32-stage square root (one root bit per stage); throughput one item per
// cycle, results leave in input order.
// config: cfg_data is the 31-bit parallel tolerance, written on an edge
// with cfg_valid high; cfg_ready is always high. write it only while no
// item is in flight.
// reset: rst_n clears the valid pipe and loads the tolerance reset value;
// items in flight are dropped.
module line_ray_distance_3d_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lrd_pkg::item_t    item,
    output logic              done,
    output lrd_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [30:0]       cfg_data
);

    localparam int DW = lrd_pkg::DIV_STAGES;

    typedef struct packed {
        logic               s_neg;
        logic               s_sat;
        logic               t_sat;
        logic signed [31:0] s_fall;
        logic [1:0]         cs;
    } side_div_t;

    typedef struct packed {
        logic signed [31:0] s;
        logic [30:0]        t;
        logic [1:0]         cs;
    } side_sel_t;

    typedef struct packed {
        logic [2:0][31:0] lp;
        logic [2:0][31:0] rp;
    } pts_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -36'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    logic                     accept;
    logic [30:0]              tol_reg;
    logic [lrd_pkg::ST_OUT:0] vld_reg;
    lrd_pkg::item_t           in_reg;

    logic signed [31:0] p0 [3];
    logic signed [31:0] u0 [3];
    logic signed [31:0] q0 [3];
    logic signed [31:0] v0 [3];

    // stage 1
    logic signed [32:0] d1_reg [3];
    logic signed [31:0] u1_reg [3];
    logic signed [31:0] v1_reg [3];
    // stage 2
    logic signed [63:0] uv_full [3];
    logic signed [64:0] du_full [3];
    logic signed [64:0] dv_full [3];
    logic signed [33:0] uv2_reg [3];
    logic signed [34:0] du2_reg [3];
    logic signed [34:0] dv2_reg [3];
    // stage 3
    logic signed [35:0] a_sum;
    logic signed [36:0] b0_sum;
    logic signed [36:0] b1_sum;
    logic signed [31:0] a3_next;
    logic signed [34:0] b0_3_next;
    logic signed [34:0] b1_3_next;
    logic signed [31:0] a3_reg;
    logic signed [34:0] b0_3_reg;
    logic signed [34:0] b1_3_reg;
    // stage 4
    logic signed [63:0] aa4_reg;
    logic signed [66:0] ab0_4_reg;
    logic signed [66:0] ab1_4_reg;
    logic signed [34:0] b0_4_reg;
    logic signed [34:0] b1_4_reg;
    // stage 5
    logic signed [63:0] aa_full;
    logic signed [66:0] ab0_full;
    logic signed [66:0] ab1_full;
    logic signed [33:0] aa_rnd;
    logic signed [36:0] ab0_rnd;
    logic signed [36:0] ab1_rnd;
    logic signed [34:0] det_full;
    logic [30:0]        det5_reg;
    logic signed [37:0] tnum5_reg;
    logic signed [37:0] snum5_reg;
    logic signed [34:0] b0_5_reg;
    // stage 6
    logic               det_ok;
    logic [37:0]        smag;
    logic [37:0]        tmag;
    logic [61:0]        s_dvd;
    logic [61:0]        t_dvd;
    logic signed [35:0] nb0;
    side_div_t          side6_next;
    side_div_t          side6_reg;
    logic [DW-1:0]      det6_reg;
    logic [DW-1:0]      srem6_reg;
    logic [DW-1:0]      slow6_reg;
    logic [DW-1:0]      trem6_reg;
    logic [DW-1:0]      tlow6_reg;
    // divider output
    logic [DW-1:0]      qs37;
    logic [DW-1:0]      qt37;
    side_div_t          side37;
    // selection stage
    side_sel_t          sel_next;
    side_sel_t          sel_reg;
    lrd_pkg::item_t     item_sel;
    // products with the parameters
    logic signed [63:0] su_full [3];
    logic signed [63:0] tv_full [3];
    logic signed [31:0] u_sel [3];
    logic signed [31:0] v_sel [3];
    logic signed [31:0] p_sel [3];
    logic signed [31:0] q_sel [3];
    logic signed [33:0] su_reg [3];
    logic signed [33:0] tv_reg [3];
    logic signed [31:0] p_pr_reg [3];
    logic signed [31:0] q_pr_reg [3];
    // closest points
    logic signed [34:0] lp_reg [3];
    logic signed [34:0] rp_reg [3];
    // clamp stage
    logic signed [35:0] diff [3];
    logic [35:0]        dmag [3];
    pts_t               pts_next;
    pts_t               pts_reg;
    logic [31:0]        m_reg [3];
    logic [2:0]         ov_reg;
    // squares
    logic [63:0]        sq_part_reg [3];
    logic               ov_sq_reg;
    // sum
    logic [65:0]        sq_sum;
    logic [63:0]        sq_reg;
    // root stage
    logic [31:0]        root;
    logic [63:0]        sq_root;
    side_sel_t          sel_root;
    pts_t               pts_root;
    lrd_pkg::result_t   result_next;
    lrd_pkg::result_t   result_reg;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= lrd_pkg::TOL_RESET;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                tol_reg <= cfg_data;
            end
            vld_reg <= {vld_reg[lrd_pkg::ST_OUT-1:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= item;
        end
    end

    assign p0[0] = in_reg.line_origin_x;
    assign p0[1] = in_reg.line_origin_y;
    assign p0[2] = in_reg.line_origin_z;
    assign u0[0] = in_reg.line_dir_x;
    assign u0[1] = in_reg.line_dir_y;
    assign u0[2] = in_reg.line_dir_z;
    assign q0[0] = in_reg.ray_origin_x;
    assign q0[1] = in_reg.ray_origin_y;
    assign q0[2] = in_reg.ray_origin_z;
    assign v0[0] = in_reg.ray_dir_x;
    assign v0[1] = in_reg.ray_dir_y;
    assign v0[2] = in_reg.ray_dir_z;

    // stage 1: origin difference
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            d1_reg[k] <= {p0[k][31], p0[k]} - {q0[k][31], q0[k]};
            u1_reg[k] <= u0[k];
            v1_reg[k] <= v0[k];
        end
    end

    // stage 2: nine products, rounded half up to drop 30 fraction bits
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            uv_full[k] = u1_reg[k] * v1_reg[k] + 64'sd536870912;
            du_full[k] = d1_reg[k] * u1_reg[k] + 65'sd536870912;
            dv_full[k] = d1_reg[k] * v1_reg[k] + 65'sd536870912;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            uv2_reg[k] <= uv_full[k][63:30];
            du2_reg[k] <= du_full[k][64:30];
            dv2_reg[k] <= dv_full[k][64:30];
        end
    end

    // stage 3: dot products and their clamps
    always_comb
    begin
        a_sum  = -(36'(uv2_reg[0]) + 36'(uv2_reg[1]) + 36'(uv2_reg[2]));
        b0_sum = 37'(du2_reg[0]) + 37'(du2_reg[1]) + 37'(du2_reg[2]);
        b1_sum = -(37'(dv2_reg[0]) + 37'(dv2_reg[1]) + 37'(dv2_reg[2]));

        if (a_sum > 36'sd1073741824)
            a3_next = 32'sd1073741824;
        else if (a_sum < -36'sd1073741824)
            a3_next = -32'sd1073741824;
        else
            a3_next = a_sum[31:0];

        if (b0_sum > 37'sd8589934591)
            b0_3_next = 35'sd8589934591;
        else if (b0_sum < -37'sd8589934591)
            b0_3_next = -35'sd8589934591;
        else
            b0_3_next = b0_sum[34:0];

        if (b1_sum > 37'sd8589934591)
            b1_3_next = 35'sd8589934591;
        else if (b1_sum < -37'sd8589934591)
            b1_3_next = -35'sd8589934591;
        else
            b1_3_next = b1_sum[34:0];
    end

    always_ff @(posedge clk)
    begin
        a3_reg   <= a3_next;
        b0_3_reg <= b0_3_next;
        b1_3_reg <= b1_3_next;
    end

    // stage 4: products with a
    always_ff @(posedge clk)
    begin
        aa4_reg   <= a3_reg * a3_reg;
        ab0_4_reg <= a3_reg * b0_3_reg;
        ab1_4_reg <= a3_reg * b1_3_reg;
        b0_4_reg  <= b0_3_reg;
        b1_4_reg  <= b1_3_reg;
    end

    // stage 5: determinant and numerators
    always_comb
    begin
        aa_full  = aa4_reg + 64'sd536870912;
        ab0_full = ab0_4_reg + 67'sd536870912;
        ab1_full = ab1_4_reg + 67'sd536870912;
        aa_rnd   = aa_full[63:30];
        ab0_rnd  = ab0_full[66:30];
        ab1_rnd  = ab1_full[66:30];
        // a is clamped to one, so det stays in [0, 1]
        det_full = 35'sd1073741824 - 35'(aa_rnd);
    end

    always_ff @(posedge clk)
    begin
        det5_reg  <= det_full[30:0];
        tnum5_reg <= 38'(ab0_rnd) - 38'(b1_4_reg);
        snum5_reg <= 38'(ab1_rnd) - 38'(b0_4_reg);
        b0_5_reg  <= b0_4_reg;
    end

    // stage 6: case decision and divider setup
    always_comb
    begin
        det_ok = (det5_reg != '0) && (det5_reg >= tol_reg);
        smag   = snum5_reg[37] ? 38'(-snum5_reg) : 38'(snum5_reg);
        tmag   = tnum5_reg[37] ? 38'(-tnum5_reg) : 38'(tnum5_reg);
        s_dvd  = {smag[31:0], 30'd0} + {32'd0, det5_reg[30:1]};
        t_dvd  = {tmag[31:0], 30'd0} + {32'd0, det5_reg[30:1]};
        nb0    = -36'(b0_5_reg);

        side6_next.s_neg  = snum5_reg[37];
        side6_next.s_sat  = (smag >= {6'd0, det5_reg, 1'b0});
        side6_next.t_sat  = (tmag >= {6'd0, det5_reg, 1'b0});
        side6_next.s_fall = sat32(nb0);
        if (!det_ok)
            side6_next.cs = lrd_pkg::CASE_PARALLEL;
        else if (tnum5_reg[37])
            side6_next.cs = lrd_pkg::CASE_CLAMPED;
        else
            side6_next.cs = lrd_pkg::CASE_INTERIOR;
    end

    always_ff @(posedge clk)
    begin
        side6_reg <= side6_next;
        det6_reg  <= det5_reg;
        srem6_reg <= s_dvd[61:31];
        slow6_reg <= s_dvd[30:0];
        trem6_reg <= t_dvd[61:31];
        tlow6_reg <= t_dvd[30:0];
    end

    lrd_div u_div_s (
        .clk    (clk),
        .dvs    (det6_reg),
        .rem_in (srem6_reg),
        .low_in (slow6_reg),
        .quo    (qs37)
    );

    lrd_div u_div_t (
        .clk    (clk),
        .dvs    (det6_reg),
        .rem_in (trem6_reg),
        .low_in (tlow6_reg),
        .quo    (qt37)
    );

    lrd_delay #(
        .WIDTH ($bits(side_div_t)),
        .DEPTH (lrd_pkg::DIV_STAGES)
    ) u_dly_div (
        .clk  (clk),
        .din  (side6_reg),
        .dout (side37)
    );

    lrd_delay #(
        .WIDTH ($bits(lrd_pkg::item_t)),
        .DEPTH (lrd_pkg::ST_SEL)
    ) u_dly_item (
        .clk  (clk),
        .din  (in_reg),
        .dout (item_sel)
    );

    // select the parameters by case, saturating the quotients
    always_comb
    begin
        sel_next.cs = side37.cs;
        if (side37.cs == lrd_pkg::CASE_INTERIOR)
        begin
            if (side37.s_sat)
                sel_next.s = side37.s_neg ? 32'sh80000000 : 32'sh7fffffff;
            else if (side37.s_neg)
                sel_next.s = -$signed({1'b0, qs37});
            else
                sel_next.s = $signed({1'b0, qs37});
            sel_next.t = side37.t_sat ? 31'h7fffffff : qt37;
        end
        else
        begin
            sel_next.s = side37.s_fall;
            sel_next.t = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
    end

    assign p_sel[0] = item_sel.line_origin_x;
    assign p_sel[1] = item_sel.line_origin_y;
    assign p_sel[2] = item_sel.line_origin_z;
    assign u_sel[0] = item_sel.line_dir_x;
    assign u_sel[1] = item_sel.line_dir_y;
    assign u_sel[2] = item_sel.line_dir_z;
    assign q_sel[0] = item_sel.ray_origin_x;
    assign q_sel[1] = item_sel.ray_origin_y;
    assign q_sel[2] = item_sel.ray_origin_z;
    assign v_sel[0] = item_sel.ray_dir_x;
    assign v_sel[1] = item_sel.ray_dir_y;
    assign v_sel[2] = item_sel.ray_dir_z;

    // parameter times direction
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            su_full[k] = sel_reg.s * u_sel[k] + 64'sd536870912;
            tv_full[k] = $signed({1'b0, sel_reg.t}) * v_sel[k] + 64'sd536870912;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            su_reg[k]   <= su_full[k][63:30];
            tv_reg[k]   <= tv_full[k][63:30];
            p_pr_reg[k] <= p_sel[k];
            q_pr_reg[k] <= q_sel[k];
        end
    end

    // closest points at full width
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            lp_reg[k] <= 35'(p_pr_reg[k]) + 35'(su_reg[k]);
            rp_reg[k] <= 35'(q_pr_reg[k]) + 35'(tv_reg[k]);
        end
    end

    // difference magnitude and output clamps
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff[k]        = 36'(lp_reg[k]) - 36'(rp_reg[k]);
            dmag[k]        = diff[k][35] ? 36'(-diff[k]) : 36'(diff[k]);
            pts_next.lp[k] = sat32(36'(lp_reg[k]));
            pts_next.rp[k] = sat32(36'(rp_reg[k]));
        end
    end

    always_ff @(posedge clk)
    begin
        pts_reg <= pts_next;
        for (int k = 0; k < 3; k++)
        begin
            m_reg[k]  <= dmag[k][31:0];
            ov_reg[k] <= (dmag[k][35:32] != 4'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq_part_reg[k] <= m_reg[k] * m_reg[k];
        end
        ov_sq_reg <= |ov_reg;
    end

    assign sq_sum = {2'b00, sq_part_reg[0]} + {2'b00, sq_part_reg[1]}
                  + {2'b00, sq_part_reg[2]};

    always_ff @(posedge clk)
    begin
        if (ov_sq_reg || (sq_sum[65:64] != 2'b00))
            sq_reg <= '1;
        else
            sq_reg <= sq_sum[63:0];
    end

    lrd_sqrt u_sqrt (
        .clk  (clk),
        .x_in (sq_reg),
        .root (root)
    );

    lrd_delay #(
        .WIDTH (64),
        .DEPTH (lrd_pkg::SQRT_STAGES)
    ) u_dly_sq (
        .clk  (clk),
        .din  (sq_reg),
        .dout (sq_root)
    );

    lrd_delay #(
        .WIDTH ($bits(side_sel_t)),
        .DEPTH (lrd_pkg::ST_ROOT - lrd_pkg::ST_SEL)
    ) u_dly_sel (
        .clk  (clk),
        .din  (sel_reg),
        .dout (sel_root)
    );

    lrd_delay #(
        .WIDTH ($bits(pts_t)),
        .DEPTH (lrd_pkg::ST_ROOT - lrd_pkg::ST_CLAMP)
    ) u_dly_pts (
        .clk  (clk),
        .din  (pts_reg),
        .dout (pts_root)
    );

    always_comb
    begin
        result_next.squared_distance = sq_root;
        result_next.distance         = root;
        result_next.line_param       = sel_root.s;
        result_next.ray_param        = sel_root.t;
        result_next.line_point_x     = pts_root.lp[0];
        result_next.line_point_y     = pts_root.lp[1];
        result_next.line_point_z     = pts_root.lp[2];
        result_next.ray_point_x      = pts_root.rp[0];
        result_next.ray_point_y      = pts_root.rp[1];
        result_next.ray_point_z      = pts_root.rp[2];
        result_next.closest_case     = sel_root.cs;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = vld_reg[lrd_pkg::ST_OUT];
    assign result = result_reg;

endmodule

// ===== rtl/lrd_checker.sv =====
// port-level checks for the line/ray distance unit and their bind
`timescale 1ns / 1ps
`include "line_ray_distance_3d_unit_assert.svh"

module lrd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input lrd_pkg::result_t  result
);

    localparam int LAT = lrd_pkg::LATENCY;

    // every accepted transfer comes back after the fixed pipe latency
    `LRD_ASSERT_LAT(a_latency, start && !busy, LAT, done, "result missing after accept")

    `LRD_ASSERT_IMP(a_case_code, done,
        result.closest_case == lrd_pkg::CASE_INTERIOR ||
        result.closest_case == lrd_pkg::CASE_CLAMPED ||
        result.closest_case == lrd_pkg::CASE_PARALLEL, "closest_case out of range")

    // off the interior case the ray point is the ray origin
    `LRD_ASSERT_IMP(a_ray_origin, done && result.closest_case != lrd_pkg::CASE_INTERIOR,
        result.ray_param == 31'd0, "ray_param not zero for clamped or parallel")

    // a saturated square gives the largest root
    `LRD_ASSERT_IMP(a_root_sat, done && result.squared_distance == 64'hFFFFFFFFFFFFFFFF,
        result.distance == 32'hFFFFFFFF, "distance does not match saturated square")

endmodule

bind line_ray_distance_3d_unit lrd_checker u_lrd_checker (.*);
